// File: hdl/brfn_pkg.sv
// shared types, codes and constants of the bitmap rank / find-next engine
`timescale 1ns / 1ps
package brfn_pkg;

  localparam int unsigned DEF_NUM_WORDS = 64;
  localparam int unsigned WORD_W        = 64;
  localparam int unsigned POS_W         = 6;
  localparam int unsigned POP_W         = 7;
  localparam int unsigned CMD_W         = 3;
  localparam int unsigned IDX_W         = 12;
  localparam int unsigned END_W         = 13;
  localparam int unsigned RES_W         = 13;
  localparam int unsigned STATUS_W      = 2;
  localparam logic [POS_W-1:0] POS_TOP  = 6'd63;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_BIT  = 3'd0,
    CMD_READ_BIT   = 3'd1,
    CMD_WRITE_SPAN = 3'd2,
    CMD_COUNT      = 3'd3,
    CMD_FIND_NEXT  = 3'd4
  } cmd_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_RANGE    = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_e;

  // one result word
  typedef struct packed {
    status_e          status;
    logic             bit_value;
    logic [RES_W-1:0] result_value;
  } res_t;

  // per-word control from the sequencer to the word unit
  typedef struct packed {
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi_m1;
    logic             first;
    logic             last;
    logic             val;
  } wu_ctl_t;

  // per-word results of the word unit
  typedef struct packed {
    logic [WORD_W-1:0] wr_data;
    logic [POP_W-1:0]  pop;
    logic              found;
    logic [POS_W-1:0]  pos;
    logic              bit_value;
  } wu_res_t;

endpackage

// File: hdl/brfn_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module brfn_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/brfn_word_unit.sv
// masking, update, popcount and lowest-set search on one bitmap word
`timescale 1ns / 1ps
module brfn_word_unit
  import brfn_pkg::*;
(
  input  wu_ctl_t           ctl_i,
  input  logic [WORD_W-1:0] rd_data_i,
  output wu_res_t           res_o
);

  logic [POS_W-1:0]  lo_eff;
  logic [POS_W-1:0]  hi_eff;
  logic [WORD_W-1:0] mask;
  logic [WORD_W-1:0] masked;
  logic [POS_W-1:0]  pos;

  // span of bits touched in this word
  assign lo_eff = ctl_i.first ? ctl_i.lo : '0;
  assign hi_eff = ctl_i.last ? ctl_i.hi_m1 : POS_TOP;
  assign mask   = ({WORD_W{1'b1}} << lo_eff) & ({WORD_W{1'b1}} >> (POS_TOP - hi_eff));
  assign masked = rd_data_i & mask;

  // lowest set bit of the masked word
  always_comb begin
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (masked[i]) begin
        pos = POS_W'(i);
      end
    end
  end

  // updated word and summaries
  assign res_o.wr_data   = ctl_i.val ? (rd_data_i | mask) : (rd_data_i & ~mask);
  assign res_o.pop       = POP_W'($countones(masked));
  assign res_o.found     = |masked;
  assign res_o.pos       = pos;
  assign res_o.bit_value = |masked;

endmodule

// File: hdl/brfn_seq.sv
// command sequencer: clearing pass, decode and word-by-word walk over the ram
`timescale 1ns / 1ps
module brfn_seq
  import brfn_pkg::*;
#(
  parameter int unsigned NUM_WORDS = DEF_NUM_WORDS,
  localparam int unsigned AW       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // command side
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [IDX_W-1:0]  bit_index_i,
  input  logic [END_W-1:0]  end_index_i,
  input  logic              write_value_i,
  // result side
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output res_t              res_o,
  // ram
  output logic              ram_we_o,
  output logic [AW-1:0]     ram_waddr_o,
  output logic [WORD_W-1:0] ram_wdata_o,
  output logic              ram_re_o,
  output logic [AW-1:0]     ram_raddr_o,
  // word unit
  output wu_ctl_t           wu_ctl_o,
  input  wu_res_t           wu_res_i
);

  localparam int unsigned CAP      = NUM_WORDS * WORD_W;
  localparam logic [AW-1:0] W_LAST = AW'(NUM_WORDS - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_WORK  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [AW-1:0]    w_q, w_d;
  logic [AW-1:0]    ew_q, ew_d;
  logic [CMD_W-1:0] cmd_q, cmd_d;
  logic [POS_W-1:0] lo_q, lo_d;
  logic [POS_W-1:0] hi_q, hi_d;
  logic             first_q, first_d;
  logic             val_q, val_d;
  status_e          status_q, status_d;
  logic             bit_q, bit_d;
  logic [RES_W-1:0] acc_q, acc_d;

  logic             accept;
  logic             last_word;
  logic             idx_oor;
  logic             end_oor;
  logic             from_oor;
  logic [END_W-1:0] last_bit;
  logic [END_W-1:0] from_bit;
  logic             word_writes;

  // range checks on the incoming command
  assign accept   = cmd_valid_i && (state_q == S_IDLE);
  assign last_bit = end_index_i - END_W'(1);
  assign from_bit = END_W'(bit_index_i) + END_W'(1);
  assign idx_oor  = 32'(bit_index_i) >= CAP;
  assign end_oor  = 32'(end_index_i) > CAP;
  assign from_oor = 32'(from_bit) >= CAP;

  assign last_word   = (w_q == ew_q);
  assign word_writes = (cmd_q == CMD_WRITE_BIT) || (cmd_q == CMD_WRITE_SPAN);

  // next-state and walk control
  always_comb begin
    state_d  = state_q;
    w_d      = w_q;
    ew_d     = ew_q;
    cmd_d    = cmd_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    first_d  = first_q;
    val_d    = val_q;
    status_d = status_q;
    bit_d    = bit_q;
    acc_d    = acc_q;
    unique case (state_q)
      S_CLEAR: begin
        if (w_q == W_LAST) begin
          state_d = S_IDLE;
        end else begin
          w_d = w_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_d    = cmd_i;
          val_d    = write_value_i;
          status_d = STAT_OK;
          bit_d    = 1'b0;
          acc_d    = '0;
          first_d  = 1'b1;
          state_d  = S_READ;
          unique case (cmd_i)
            CMD_WRITE_BIT, CMD_READ_BIT: begin
              w_d  = AW'(bit_index_i >> POS_W);
              ew_d = AW'(bit_index_i >> POS_W);
              lo_d = bit_index_i[POS_W-1:0];
              hi_d = bit_index_i[POS_W-1:0];
              if (idx_oor) begin
                status_d = STAT_RANGE;
                state_d  = S_DONE;
              end
            end
            CMD_WRITE_SPAN: begin
              w_d  = AW'(bit_index_i >> POS_W);
              ew_d = AW'(last_bit >> POS_W);
              lo_d = bit_index_i[POS_W-1:0];
              hi_d = last_bit[POS_W-1:0];
              if (idx_oor || end_oor) begin
                status_d = STAT_RANGE;
                state_d  = S_DONE;
              end else if (end_index_i <= END_W'(bit_index_i)) begin
                status_d = STAT_EMPTY;
                state_d  = S_DONE;
              end
            end
            CMD_COUNT: begin
              w_d  = '0;
              ew_d = AW'(last_bit >> POS_W);
              lo_d = '0;
              hi_d = last_bit[POS_W-1:0];
              if (end_oor) begin
                status_d = STAT_RANGE;
                state_d  = S_DONE;
              end else if (end_index_i == '0) begin
                state_d = S_DONE;
              end
            end
            CMD_FIND_NEXT: begin
              w_d  = AW'(from_bit >> POS_W);
              ew_d = W_LAST;
              lo_d = from_bit[POS_W-1:0];
              hi_d = POS_TOP;
              if (idx_oor) begin
                status_d = STAT_RANGE;
                state_d  = S_DONE;
              end else if (from_oor) begin
                status_d = STAT_NOTFOUND;
                state_d  = S_DONE;
              end
            end
            default: begin
              status_d = STAT_RANGE;
              state_d  = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        state_d = S_WORK;
      end
      S_WORK: begin
        first_d = 1'b0;
        state_d = last_word ? S_DONE : S_WORK;
        unique case (cmd_q)
          CMD_READ_BIT: begin
            bit_d = wu_res_i.bit_value;
          end
          CMD_COUNT: begin
            acc_d = acc_q + RES_W'(wu_res_i.pop);
          end
          CMD_FIND_NEXT: begin
            if (wu_res_i.found) begin
              acc_d   = RES_W'({w_q, wu_res_i.pos});
              state_d = S_DONE;
            end else if (last_word) begin
              status_d = STAT_NOTFOUND;
            end
          end
          default: begin
          end
        endcase
        if (state_d == S_WORK) begin
          w_d = w_q + AW'(1);
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      w_q     <= '0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      w_q     <= w_d;
      first_q <= first_d;
    end
  end

  // command payload and result registers
  always_ff @(posedge clk_i) begin
    ew_q     <= ew_d;
    cmd_q    <= cmd_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    val_q    <= val_d;
    status_q <= status_d;
    bit_q    <= bit_d;
    acc_q    <= acc_d;
  end

  // ram and word unit drive
  assign ram_we_o    = (state_q == S_CLEAR) || ((state_q == S_WORK) && word_writes);
  assign ram_waddr_o = w_q;
  assign ram_wdata_o = (state_q == S_CLEAR) ? '0 : wu_res_i.wr_data;
  assign ram_re_o    = (state_q == S_READ) || ((state_q == S_WORK) && (state_d == S_WORK));
  assign ram_raddr_o = (state_q == S_READ) ? w_q : w_q + AW'(1);

  assign wu_ctl_o.lo    = lo_q;
  assign wu_ctl_o.hi_m1 = hi_q;
  assign wu_ctl_o.first = first_q;
  assign wu_ctl_o.last  = last_word;
  assign wu_ctl_o.val   = val_q;

  // handshakes and result
  assign cmd_ready_o         = (state_q == S_IDLE);
  assign res_valid_o         = (state_q == S_DONE);
  assign res_o.status        = status_q;
  assign res_o.bit_value     = bit_q;
  assign res_o.result_value  = acc_q;

`ifndef SYNTH
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !ram_we_o)
    else $error("ram written while idle");
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WORK) |-> (w_q <= ew_q))
    else $error("word walk passed its last word");
  a_done_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && res_ready_i) |=> (state_q == S_IDLE))
    else $error("result handed over but sequencer not idle");
  a_clear_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_CLEAR) && (state_d == S_IDLE)) |-> (w_q == W_LAST))
    else $error("clearing pass ended early");
`endif

endmodule

// File: hdl/bitmap_rank_find_next_engine.sv
// Bitmap rank / find-next engine top level.
// Holds NUM_WORDS x 64 bits in one ram, all zero after reset.
// Slave channel: one command word per handshake; tuser carries cmd,
//   tdata carries bit_index, end_index and write_value.
// Master channel: one result word per command; tuser carries status,
//   tdata carries bit_value and result_value.
// After reset a clearing pass writes zero to every ram word, one word per
//   cycle, and s_axis_tready stays low until the pass ends.
// Commands run one at a time through the ram's single read and write port.
// Steps per command, from accept to the result in the output register:
//   errors, empty ranges and count to zero: straight to the result
//   bit write and bit read: read the one word, then work on it
//   range write and count: read the first word, then walk each word in range
//   find next: read the first word, then walk up to the first set bit or the last word
// The walk touches one 64-bit word per cycle (read, update, write back).
// The next command is accepted the cycle after the result is registered,
//   even while that result waits on m_axis_tready; a stalled output keeps
//   the result and holds the following one inside the sequencer.
`timescale 1ns / 1ps
module bitmap_rank_find_next_engine
  import brfn_pkg::*;
#(
  parameter int unsigned NUM_WORDS = DEF_NUM_WORDS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // bit_index[11:0], end_index[24:12], write_value[25]
  input  logic [2:0]  s_axis_tuser,  // cmd[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // bit_value[0], result_value[13:1]
  output logic [1:0]  m_axis_tuser   // status[1:0]
);

  localparam int unsigned AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  wu_ctl_t           wu_ctl;
  wu_res_t           wu_res;
  logic              out_valid_q, out_valid_d;
  res_t              out_q;

  brfn_seq #(
    .NUM_WORDS (NUM_WORDS)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (s_axis_tvalid),
    .cmd_ready_o   (s_axis_tready),
    .cmd_i         (s_axis_tuser),
    .bit_index_i   (s_axis_tdata[11:0]),
    .end_index_i   (s_axis_tdata[24:12]),
    .write_value_i (s_axis_tdata[25]),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .wu_ctl_o      (wu_ctl),
    .wu_res_i      (wu_res)
  );

  brfn_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  brfn_word_unit u_word_unit (
    .ctl_i     (wu_ctl),
    .rd_data_i (ram_rdata),
    .res_o     (wu_res)
  );

  // output register
  assign res_ready   = !out_valid_q || m_axis_tready;
  assign out_valid_d = res_valid || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.result_value, out_q.bit_value};
  assign m_axis_tuser  = out_q.status;

endmodule

// File: tb/bitmap_rank_find_next_engine_tb.sv
// self-checking testbench of the bitmap rank / find-next engine: directed table, then random
`timescale 1ns / 1ps
module bitmap_rank_find_next_engine_tb;
  import brfn_pkg::*;

  localparam int unsigned NUM_WORDS     = DEF_NUM_WORDS;
  localparam int unsigned CAPACITY      = NUM_WORDS * WORD_W;
  localparam int unsigned RANDOM_ITEMS  = 500;
  localparam int unsigned QUIET_ITEMS   = 100;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned DRAIN_CYCLES  = 100;
  localparam int unsigned STALL_LIMIT   = 2000;
  // codes with no command behind them
  localparam int unsigned CMD_BAD_FIRST = 5;
  localparam int unsigned CMD_BAD_LAST  = 7;

  // one command word with an optional hand-written expectation
  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] idx;
    logic [END_W-1:0] end_idx;
    logic             wval;
    bit               typed;
    res_t             want;
  } cmd_word_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata;
  logic [2:0]        s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [15:0]       m_axis_tdata;
  logic [1:0]        m_axis_tuser;

  logic [WORD_W-1:0] bitmap_words [NUM_WORDS];
  res_t              pending_results [$];
  cmd_word_t         directed_rows [$];
  res_t              oldest_result;
  int unsigned       mismatches;
  int unsigned       quiet_cycles;
  bit                quiet_phase;
  bit                long_hold_req;

  bitmap_rank_find_next_engine #(
    .NUM_WORDS(NUM_WORDS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // bit-serial model of one command: updates the bitmap copy, returns the result word
  function automatic res_t run_bitmap_cmd(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                                          logic [END_W-1:0] end_idx, logic wval);
    res_t        r;
    int unsigned ix;
    int unsigned en;
    int unsigned n;
    bit          found;
    ix = idx;
    en = end_idx;
    n = 0;
    found = 1'b0;
    r.status = STAT_OK;
    r.bit_value = 1'b0;
    r.result_value = '0;
    case (cmd)
      CMD_WRITE_BIT: begin
        if (ix >= CAPACITY) r.status = STAT_RANGE;
        else bitmap_words[ix / WORD_W][ix % WORD_W] = wval;
      end
      CMD_READ_BIT: begin
        if (ix >= CAPACITY) r.status = STAT_RANGE;
        else r.bit_value = bitmap_words[ix / WORD_W][ix % WORD_W];
      end
      CMD_WRITE_SPAN: begin
        if (ix >= CAPACITY || en > CAPACITY) begin
          r.status = STAT_RANGE;
        end else if (en <= ix) begin
          r.status = STAT_EMPTY;
        end else begin
          for (int unsigned b = ix; b < en; b++) bitmap_words[b / WORD_W][b % WORD_W] = wval;
        end
      end
      CMD_COUNT: begin
        if (en > CAPACITY) begin
          r.status = STAT_RANGE;
        end else begin
          for (int unsigned b = 0; b < en; b++) n += bitmap_words[b / WORD_W][b % WORD_W];
          r.result_value = RES_W'(n);
        end
      end
      CMD_FIND_NEXT: begin
        if (ix >= CAPACITY) begin
          r.status = STAT_RANGE;
        end else begin
          // origin itself is excluded from the search
          for (int unsigned b = ix + 1; b < CAPACITY && !found; b++) begin
            if (bitmap_words[b / WORD_W][b % WORD_W]) begin
              r.result_value = RES_W'(b);
              found = 1'b1;
            end
          end
          if (!found) r.status = STAT_NOTFOUND;
        end
      end
      default: r.status = STAT_RANGE;
    endcase
    return r;
  endfunction

  // table row checked against the bitmap model
  function automatic void add_row(logic [CMD_W-1:0] cmd, int unsigned idx, int unsigned end_idx,
                                  logic wval);
    cmd_word_t w;
    w.cmd = cmd;
    w.idx = IDX_W'(idx);
    w.end_idx = END_W'(end_idx);
    w.wval = wval;
    w.typed = 1'b0;
    w.want = '0;
    directed_rows.push_back(w);
  endfunction

  // table row with its result written out
  function automatic void add_checked_row(logic [CMD_W-1:0] cmd, int unsigned idx,
                                          int unsigned end_idx, logic wval, status_e st,
                                          logic bv, int unsigned rv);
    cmd_word_t w;
    w.cmd = cmd;
    w.idx = IDX_W'(idx);
    w.end_idx = END_W'(end_idx);
    w.wval = wval;
    w.typed = 1'b1;
    w.want.status = st;
    w.want.bit_value = bv;
    w.want.result_value = RES_W'(rv);
    directed_rows.push_back(w);
  endfunction

  // random command word, biased toward word edges and short spans
  function automatic cmd_word_t random_cmd();
    cmd_word_t   w;
    int unsigned pick;
    int unsigned len;
    w.typed = 1'b0;
    w.want = '0;
    w.wval = 1'($urandom_range(0, 1));
    w.end_idx = END_W'($urandom);
    case ($urandom_range(0, 5))
      0, 1: w.idx = IDX_W'($urandom);
      2: w.idx = IDX_W'($urandom_range(0, NUM_WORDS - 1) * WORD_W
                        + (($urandom_range(0, 1) == 0) ? $urandom_range(0, 1)
                                                       : $urandom_range(WORD_W - 2, WORD_W - 1)));
      3: w.idx = ($urandom_range(0, 1) == 0) ? '0 : IDX_W'(CAPACITY - 1);
      default: w.idx = IDX_W'($urandom_range(0, 511));
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      w.cmd = CMD_WRITE_BIT;
    end else if (pick < 24) begin
      w.cmd = CMD_READ_BIT;
    end else if (pick < 52) begin
      w.cmd = CMD_WRITE_SPAN;
      case ($urandom_range(0, 9))
        0: ;  // keep the fully random end
        1: w.end_idx = END_W'($urandom_range(0, w.idx));
        default: begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, CAPACITY)
                                            : $urandom_range(1, 160);
          w.end_idx = END_W'(w.idx + len);
        end
      endcase
    end else if (pick < 70) begin
      w.cmd = CMD_COUNT;
      if ($urandom_range(0, 7) != 0) w.end_idx = END_W'($urandom_range(0, CAPACITY));
    end else if (pick < 95) begin
      w.cmd = CMD_FIND_NEXT;
    end else begin
      w.cmd = CMD_W'($urandom_range(CMD_BAD_FIRST, CMD_BAD_LAST));
    end
    return w;
  endfunction

  // offer one command word, predict its result once it is taken
  task automatic send_cmd(cmd_word_t w);
    res_t predicted;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 8)) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, w.wval, w.end_idx, w.idx};
    s_axis_tuser  <= w.cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = run_bitmap_cmd(w.cmd, w.idx, w.end_idx, w.wval);
    pending_results.push_back(w.typed ? w.want : predicted);
  endtask

  // hold the input idle until every result is back
  task automatic wait_results_drained();
    do begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end while (pending_results.size() != 0);
  endtask

  // main sequence
  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    mismatches = 0;
    quiet_phase = 1'b0;
    long_hold_req = 1'b0;
    for (int i = 0; i < NUM_WORDS; i++) bitmap_words[i] = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty bitmap, extremes and error codes
    add_checked_row(CMD_READ_BIT,   0,            0,            1'b0, STAT_OK,       1'b0, 0);
    add_checked_row(CMD_COUNT,      0,            CAPACITY,     1'b0, STAT_OK,       1'b0, 0);
    add_checked_row(CMD_FIND_NEXT,  0,            0,            1'b0, STAT_NOTFOUND, 1'b0, 0);
    add_checked_row(CMD_WRITE_BIT,  CAPACITY - 1, 0,            1'b1, STAT_OK,       1'b0, 0);
    add_checked_row(CMD_READ_BIT,   CAPACITY - 1, 0,            1'b0, STAT_OK,       1'b1, 0);
    add_checked_row(CMD_FIND_NEXT,  CAPACITY - 1, 0,            1'b0, STAT_NOTFOUND, 1'b0, 0);
    add_checked_row(CMD_FIND_NEXT,  0,            0,            1'b0, STAT_OK, 1'b0, CAPACITY - 1);
    add_checked_row(CMD_WRITE_BIT,  0,            0,            1'b1, STAT_OK,       1'b0, 0);
    // the origin bit is set but not reported
    add_checked_row(CMD_FIND_NEXT,  0,            0,            1'b0, STAT_OK, 1'b0, CAPACITY - 1);
    add_checked_row(CMD_COUNT,      0,            CAPACITY,     1'b0, STAT_OK,       1'b0, 2);
    add_checked_row(CMD_COUNT,      0,            0,            1'b0, STAT_OK,       1'b0, 0);
    add_checked_row(CMD_COUNT,      0,            CAPACITY + 1, 1'b0, STAT_RANGE,    1'b0, 0);
    add_checked_row(CMD_COUNT,      CAPACITY - 1, 8191,         1'b1, STAT_RANGE,    1'b0, 0);
    add_checked_row(CMD_WRITE_SPAN, 10,           10,           1'b1, STAT_EMPTY,    1'b0, 0);
    add_checked_row(CMD_WRITE_SPAN, 100,          50,           1'b1, STAT_EMPTY,    1'b0, 0);
    // an end index one past the capacity is out of range
    add_checked_row(CMD_WRITE_SPAN, CAPACITY - 1, CAPACITY + 1, 1'b1, STAT_RANGE,    1'b0, 0);
    // span covering whole middle words
    add_row(CMD_WRITE_SPAN, 60, 200, 1'b1);
    add_row(CMD_COUNT,      0,  130, 1'b0);
    add_row(CMD_FIND_NEXT,  63, 0,   1'b0);
    add_checked_row(CMD_WRITE_SPAN, 0,            CAPACITY,     1'b1, STAT_OK,       1'b0, 0);
    add_checked_row(CMD_COUNT,      0,            CAPACITY,     1'b0, STAT_OK, 1'b0, CAPACITY);
    add_row(CMD_WRITE_SPAN, 1, CAPACITY - 1, 1'b0);
    add_row(CMD_FIND_NEXT,  0, 0,            1'b0);
    add_checked_row(CMD_W'(CMD_BAD_FIRST), 7,     9,            1'b1, STAT_RANGE,    1'b0, 0);
    add_checked_row(CMD_W'(CMD_BAD_LAST),  0,     0,            1'b0, STAT_RANGE,    1'b0, 0);
    add_row(CMD_WRITE_BIT,  CAPACITY - 1, 0, 1'b0);
    add_row(CMD_READ_BIT,   CAPACITY - 1, 0, 1'b0);
    foreach (directed_rows[i]) send_cmd(directed_rows[i]);
    wait_results_drained();

    // random part; long output stall, a full drain, then no idling at the tail
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 150) long_hold_req = 1'b1;
      if (i == 300) wait_results_drained();
      if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet_phase = 1'b1;
      send_cmd(random_cmd());
    end
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // result receiver: random stall bursts, one long hold-off on request
  initial begin
    int unsigned run_left;
    int unsigned stall_left;
    int unsigned hold_left;
    run_left = 0;
    stall_left = 0;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (run_left == 0 && stall_left == 0) begin
        if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 8);
        run_left = $urandom_range(1, 12);
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (quiet_phase) begin
        m_axis_tready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        run_left--;
        m_axis_tready <= 1'b1;
      end
    end
  end

  // compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result word with none pending: status %0d bit %0d value %0d",
                 $time, m_axis_tuser, m_axis_tdata[0], m_axis_tdata[13:1]);
      end else begin
        oldest_result = pending_results.pop_front();
        if (m_axis_tuser !== oldest_result.status) begin
          mismatches++;
          $display("%0t: status expected %0d actual %0d", $time, oldest_result.status,
                   m_axis_tuser);
        end
        if (m_axis_tdata[0] !== oldest_result.bit_value) begin
          mismatches++;
          $display("%0t: bit_value expected %0d actual %0d", $time, oldest_result.bit_value,
                   m_axis_tdata[0]);
        end
        if (m_axis_tdata[13:1] !== oldest_result.result_value) begin
          mismatches++;
          $display("%0t: result_value expected %0d actual %0d", $time,
                   oldest_result.result_value, m_axis_tdata[13:1]);
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// File: files.f
hdl/brfn_pkg.sv
hdl/brfn_ram.sv
hdl/brfn_word_unit.sv
hdl/brfn_seq.sv
hdl/bitmap_rank_find_next_engine.sv
tb/bitmap_rank_find_next_engine_tb.sv
